>>> rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, command and status codes,
// and the entry and control types shared by the cell row and the top level.
// No dependencies.
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PRIO_W      = 32;
   localparam int DATA_W      = 32;
   localparam int OCC_W       = 5;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                     valid;
      logic signed [PRIO_W-1:0] prio;
      logic signed [DATA_W-1:0] payload;
   } spq_entry_type;

   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [PRIO_W-1:0] prio;
      logic signed [DATA_W-1:0] payload;
   } spq_ctrl_type;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry, compares it with a pushed
// entry and shifts toward the tail on push or toward the head on pop.
// Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  spq_pkg::spq_entry_type left_entry,
   input  logic                  left_ins,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type entry,
   output logic                  ins
);
   import spq_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic signed [DATA_W-1:0] payload_ff, payload_in;

   // New entry lands here or earlier when this slot is empty or holds a
   // strictly lower priority; equal priorities stay ahead.
   assign ins = !valid_ff || (prio_ff < ctrl.prio);

   always_comb begin
      valid_in   = valid_ff;
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.push) begin
         if (left_ins) begin
            valid_in   = left_entry.valid;
            prio_in    = left_entry.prio;
            payload_in = left_entry.payload;
         end else if (ins) begin
            valid_in   = 1'b1;
            prio_in    = ctrl.prio;
            payload_in = ctrl.payload;
         end
      end else if (ctrl.pop) begin
         valid_in   = right_entry.valid;
         prio_in    = right_entry.prio;
         payload_in = right_entry.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign entry = '{valid: valid_ff, prio: prio_ff, payload: payload_ff};

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, occupancy count,
// result register and the row of spq_cell slots. Depends on spq_pkg, spq_cell.
//
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata prio, payload; tuser command
// rsp      out        rsp_tvalid/rsp_tready   tdata prio, payload, occupancy;
//                                             tuser status
//
// All slots compare against the pushed priority in parallel and shift by
// one place at the same edge, so the slot compare plus neighbor hand-off
// sets the clock, and one transaction is taken per cycle while the result
// register drains.
// Reset empties the row by clearing slot valid bits and the count.
// A stalled result holds in the output register; a new transaction is
// taken in the same cycle that the waiting result is taken.
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] item_priority, [63:32] item_payload
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] out_priority, [63:32] out_payload,
                                    // [68:64] occupancy, [71:69] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import spq_pkg::*;

   logic                     accept;
   logic                     cmd;
   logic                     full, empty;
   spq_ctrl_type             ctrl;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic signed [DATA_W-1:0] rsp_payload_ff, rsp_payload_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic [CNT_W+OCC_W-1:0]   count_wide;

   spq_entry_type            entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   ins_vec;

   // Take a transaction whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser[0];

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   assign ctrl.push    = accept && (cmd == CMD_PUSH) && !full;
   assign ctrl.pop     = accept && (cmd == CMD_POP) && !empty;
   assign ctrl.prio    = req_tdata[31:0];
   assign ctrl.payload = req_tdata[63:32];

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         spq_entry_type left_e, right_e;
         logic          left_i;
         if (gi == 0) begin : g_head
            assign left_e = '0;
            assign left_i = 1'b0;
         end else begin : g_mid
            assign left_e = entries[gi-1];
            assign left_i = ins_vec[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_e = '0;
         end else begin : g_body
            assign right_e = entries[gi+1];
         end
         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_ins    (left_i),
            .right_entry (right_e),
            .entry       (entries[gi]),
            .ins         (ins_vec[gi])
         );
      end
   endgenerate

   // Build the result and the next count.
   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_prio_in    = '0;
         rsp_payload_in = '0;
         rsp_status_in  = STATUS_OK;
         if (cmd == CMD_POP) begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_prio_in    = entries[0].prio;
               rsp_payload_in = entries[0].payload;
            end
         end else if (full) begin
            rsp_status_in = STATUS_FULL;
         end
      end
   end

   // Mask the count to the occupancy field width.
   assign count_wide = {{OCC_W{1'b0}}, count_in};
   assign rsp_occ_in = accept ? count_wide[OCC_W-1:0] : rsp_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prio_ff    <= rsp_prio_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_payload_ff, rsp_prio_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue. Push and pop transactions
// go in with random gaps and result stalls, and each result is checked against
// a predictor. Depends on spq_pkg and the sorted_priority_queue RTL.
module testbench;
   import spq_pkg::*;

   localparam int IDLE_MAX       = 18;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES   = 10;    // slack after the last expected result
   localparam int FILL_ROUNDS    = 3;
   localparam int RANDOM_ITEMS   = 1780;

   typedef struct {
      logic signed [PRIO_W-1:0] prio;
      logic signed [DATA_W-1:0] payload;
   } queued_entry_type;

   typedef struct {
      logic signed [PRIO_W-1:0] prio;
      logic signed [DATA_W-1:0] payload;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } queue_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] item_priority, [63:32] item_payload
   logic [0:0]  req_tuser  = '0;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [31:0] out_priority, [63:32] out_payload,
                                   // [68:64] occupancy, [71:69] zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   // Predictor state: entries kept sorted, highest priority at index 0.
   queued_entry_type sorted_entries[QUEUE_DEPTH];
   int               stored_count = 0;
   queue_result_type pending_results[$];

   int error_count  = 0;
   int quiet_cycles = 0;
   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Apply one accepted command to the predictor and queue its expected result.
   function automatic void predict_queue_step(input logic cmd,
                                              input logic signed [PRIO_W-1:0] prio,
                                              input logic signed [DATA_W-1:0] payload);
      queue_result_type want;
      int               pos;
      int               i;
      want.prio    = '0;
      want.payload = '0;
      want.status  = STATUS_OK;
      if (cmd == CMD_PUSH) begin
         if (stored_count >= QUEUE_DEPTH) begin
            want.status = STATUS_FULL;
         end else begin
            // Insert behind every entry of greater or equal priority.
            pos = 0;
            while (pos < stored_count && sorted_entries[pos].prio >= prio)
               pos++;
            for (i = stored_count; i > pos; i--)
               sorted_entries[i] = sorted_entries[i - 1];
            sorted_entries[pos].prio    = prio;
            sorted_entries[pos].payload = payload;
            stored_count++;
         end
      end else begin
         if (stored_count == 0) begin
            want.status = STATUS_EMPTY;
         end else begin
            want.prio    = sorted_entries[0].prio;
            want.payload = sorted_entries[0].payload;
            for (i = 1; i < stored_count; i++)
               sorted_entries[i - 1] = sorted_entries[i];
            stored_count--;
         end
      end
      want.occupancy = OCC_W'(stored_count);
      pending_results.push_back(want);
   endfunction

   // Draw the idle cycles before the next transaction; now and then toggle
   // idling off so that back-to-back stretches occur as well.
   function automatic int draw_idle(inout bit idle_on);
      if ($urandom_range(0, 39) == 0)
         idle_on = !idle_on;
      return idle_on ? int'($urandom_range(0, IDLE_MAX)) : 0;
   endfunction

   // Mix of tie-prone small values, extremes and full-range values.
   function automatic logic signed [PRIO_W-1:0] pick_priority();
      logic signed [PRIO_W-1:0] extremes [4];
      int                       tie;
      extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF};
      tie      = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
         0: begin
            return tie - 3;
         end
         1: begin
            return extremes[$urandom_range(0, 3)];
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic void compare_field(input string name,
                                         input logic signed [63:0] want,
                                         input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Send one transaction: hold valid low for a random gap, then present the
   // item and hold it until it is taken.
   task automatic send_command(input logic cmd,
                               input logic signed [PRIO_W-1:0] prio,
                               input logic signed [DATA_W-1:0] payload);
      int gap;
      gap = draw_idle(req_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {payload, prio};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      predict_queue_step(cmd, prio, payload);
   endtask

   task automatic check_queue_result();
      queue_result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result: priority %0d payload %0d status %0d occupancy %0d",
                $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]), rsp_tuser,
                rsp_tdata[68:64]);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("out_priority", 64'(want.prio), 64'($signed(rsp_tdata[31:0])));
      compare_field("out_payload", 64'(want.payload), 64'($signed(rsp_tdata[63:32])));
      compare_field("status", 64'(want.status), 64'(rsp_tuser));
      compare_field("occupancy", 64'(want.occupancy), 64'(rsp_tdata[68:64]));
   endtask

   // Pop right after reset: empty status, zero fields; pop fields are ignored.
   task automatic test_pop_empty();
      send_command(CMD_POP, '0, '0);
      send_command(CMD_POP, '1, '1);
   endtask

   // Push the priority and payload extremes, drain, then pop once more on empty.
   task automatic test_extreme_values();
      send_command(CMD_PUSH, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_command(CMD_PUSH, 32'sh0000_0000, 32'shFFFF_FFFF);
      send_command(CMD_PUSH, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_command(CMD_PUSH, 32'shFFFF_FFFF, 32'sh0000_0000);
      repeat (5) send_command(CMD_POP, 32'sh5A5A_A5A5, 32'shA5A5_5A5A);
   endtask

   // Equal priorities must leave in arrival order; a later higher one jumps ahead.
   task automatic test_equal_priority_order();
      send_command(CMD_PUSH, 32'sd5, 32'sd1);
      send_command(CMD_PUSH, 32'sd5, 32'sd2);
      send_command(CMD_PUSH, 32'sd5, 32'sd3);
      send_command(CMD_PUSH, 32'sd9, 32'sd4);
      repeat (4) send_command(CMD_POP, '0, '0);
   endtask

   // Fill to capacity with random entries, push past full, then drain past empty.
   task automatic test_fill_and_overflow(input int rounds);
      int r;
      for (r = 0; r < rounds; r++) begin
         repeat (QUEUE_DEPTH) send_command(CMD_PUSH, pick_priority(), $urandom);
         repeat ($urandom_range(1, 3)) send_command(CMD_PUSH, pick_priority(), $urandom);
         repeat (QUEUE_DEPTH + 1) send_command(CMD_POP, $urandom, $urandom);
      end
   endtask

   // Phases of push-heavy, balanced and pop-heavy traffic so that occupancy
   // sweeps the whole range, with full and empty hit repeatedly.
   task automatic test_random_traffic(input int items);
      int sent;
      int phase_len;
      int push_pct;
      sent = 0;
      while (sent < items) begin
         phase_len = $urandom_range(20, 120);
         case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 25;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < push_pct)
               send_command(CMD_PUSH, pick_priority(), $urandom);
            else
               send_command(CMD_POP, $urandom, $urandom);
            sent++;
         end
      end
   endtask

   // Result side: stall a random number of cycles per result, then take and
   // check it.
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_idle(rsp_idle_on);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         check_queue_result();
      end
   end

   // Watchdog: end the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_pop_empty();
      test_extreme_values();
      test_equal_priority_order();
      test_fill_and_overflow(FILL_ROUNDS);
      test_random_traffic(RANDOM_ITEMS);

      // Drop valid, wait for every expected result, then let the pipe settle.
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
